// ----- src/korean_japanese_text_classifier_unit_macros.svh -----
// Assertion macros shared by the classifier RTL.
`ifndef KOREAN_JAPANESE_TEXT_CLASSIFIER_UNIT_MACROS_SVH
`define KOREAN_JAPANESE_TEXT_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KJTC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kjtc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KJTC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kjtc: next-cycle check failed");

`endif

// ----- src/kjtc_pkg.sv -----
// Shared types, constants and byte classification functions for the classifier.
`timescale 1ns / 1ps

package kjtc_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int BYTE_W       = 8;
  localparam int RES_W        = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int M_TDATA_W    = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_ROMAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NO_ROUND = 2'd2;

  // Decision rule codes carried in the level register.
  localparam logic [7:0] LEVEL_NO_JAPANESE = 8'd0;
  localparam logic [7:0] LEVEL_MAJORITY    = 8'd5;
  localparam logic [7:0] LEVEL_TWICE       = 8'd10;
  localparam logic [7:0] LEVEL_THRICE      = 8'd15;
  localparam logic [7:0] LEVEL_ANY_KOREAN  = 8'd20;
  localparam logic [7:0] LEVEL_RESET       = LEVEL_TWICE;

  // Remap constants.
  localparam logic [15:0] SJIS_LO_0  = 16'h889F;
  localparam logic [15:0] SJIS_HI_0  = 16'h9872;
  localparam logic [15:0] SJIS_LO_1  = 16'h989F;
  localparam logic [15:0] SJIS_HI_1  = 16'h9FFC;
  localparam logic [15:0] SJIS_LO_2  = 16'hE040;
  localparam logic [15:0] SJIS_HI_2  = 16'hEAA4;
  localparam logic [15:0] SJIS_LO_3  = 16'hED40;
  localparam logic [15:0] SJIS_HI_3  = 16'hEEEC;
  localparam logic [15:0] ROW_STRIDE = 16'd189;
  localparam logic [15:0] MAP_LIMIT  = 16'd19450;
  localparam logic [15:0] GAP_KANJI2 = 16'd12096;
  localparam logic [7:0]  KSC_BASE   = 8'hA0;
  localparam logic [13:0] RECIP_5    = 14'd13108;

  typedef struct packed {
    logic [7:0] level;
    logic       no_roman;
    logic       no_round;
  } cfg_t;

  // One queue entry: an optional byte pair and an end-of-string mark.
  typedef struct packed {
    logic       fin;
    logic       pair;
    logic [7:0] hi;
    logic [7:0] lo;
  } qent_t;

  function automatic logic sjis_lead(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  endfunction

  function automatic logic in_sjis_ranges(input logic [15:0] w);
    return (w >= SJIS_LO_0 && w <= SJIS_HI_0) || (w >= SJIS_LO_1 && w <= SJIS_HI_1) ||
           (w >= SJIS_LO_2 && w <= SJIS_HI_2) || (w >= SJIS_LO_3 && w <= SJIS_HI_3);
  endfunction

  // Hangul, symbol and full-width rows, plus the optional Roman and circled rows.
  function automatic logic korean_pair(input logic [7:0] hi, input logic [7:0] lo,
                                       input cfg_t cfg);
    logic row_ok;
    logic roman;
    logic round;
    row_ok = (lo >= 8'hA1 && lo <= 8'hFE);
    roman  = !cfg.no_roman && hi == 8'hA5 &&
             ((lo >= 8'hA1 && lo <= 8'hAA) || (lo >= 8'hB0 && lo <= 8'hB9));
    round  = !cfg.no_round && hi == 8'hA8 && lo >= 8'hE7 && lo <= 8'hF5;
    return ((hi >= 8'hB0 && hi <= 8'hC8) && row_ok) ||
           ((hi == 8'hA1 || hi == 8'hA3) && row_ok) || roman || round;
  endfunction

endpackage

// ----- src/kjtc_front.sv -----
// Front end: accepts text bytes, pairs high bytes with their partner and queues work.
`timescale 1ns / 1ps

module kjtc_front (
  input  logic              clk,
  input  logic              rst,
  input  kjtc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              in_ready,
  output logic              q_push,
  output kjtc_pkg::qent_t   q_ent,
  output logic              pend_valid
);

  logic       pend_valid_next;
  logic [7:0] pend_byte;
  logic       accept;
  logic       fin;
  logic       consumed;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign fin      = (in_byte == 8'h00);

  // A partner byte is used up by a lead byte, or by a pair that is Korean.
  // Lead bytes are the only ones that can be remapped, so the direct check suffices.
  assign consumed = kjtc_pkg::sjis_lead(pend_byte) ||
                    kjtc_pkg::korean_pair(pend_byte, in_byte, cfg);

  assign q_push    = accept && (pend_valid || fin);
  assign q_ent.fin  = fin;
  assign q_ent.pair = pend_valid;
  assign q_ent.hi   = pend_byte;
  assign q_ent.lo   = in_byte;

  // A high byte that was not consumed waits for its partner.
  always_comb begin
    pend_valid_next = pend_valid;
    if (accept) begin
      pend_valid_next = !fin && in_byte[7] && !(pend_valid && consumed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_byte <= in_byte;
    end
  end

endmodule

// ----- src/kjtc_queue.sv -----
// Short queue between the front end and the classification pipeline.
`timescale 1ns / 1ps

module kjtc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kjtc_pkg::qent_t   push_ent,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output kjtc_pkg::qent_t   head
);

  localparam int PTR_W = $clog2(kjtc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(kjtc_pkg::QUEUE_DEPTH + 1);

  kjtc_pkg::qent_t slots [kjtc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full   = (count == CNT_W'(kjtc_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

// ----- src/kjtc_remap.sv -----
// Back-end pipeline: Shift-JIS to KS C 5601 remap and Korean pair classification.
`timescale 1ns / 1ps

module kjtc_remap (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  kjtc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  kjtc_pkg::qent_t   in_ent,
  output logic              out_valid,
  output kjtc_pkg::qent_t   out_ent,
  output logic              out_kor
);

  // Stage valid bits.
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // Stage payloads.
  kjtc_pkg::qent_t s1_ent, s2_ent, s3_ent, s4_ent;
  logic            s1_map, s2_map, s3_map;
  logic [15:0]     s1_t, s2_t, s3_t;
  logic [8:0]      s3_q;

  // Stage 1: linear index of the pair.
  logic [15:0] hi_off;
  logic [15:0] t_lin;
  logic        map_lin;

  assign hi_off  = {8'h00, in_ent.hi} - 16'h0088;
  assign t_lin   = 16'(hi_off * kjtc_pkg::ROW_STRIDE) + ({8'h00, in_ent.lo} - 16'h0040);
  assign map_lin = kjtc_pkg::in_sjis_ranges({in_ent.hi, in_ent.lo}) &&
                   (t_lin <= kjtc_pkg::MAP_LIMIT);

  // Stage 2: close the gaps between the code blocks.
  logic [15:0] t_a, t_b, t_c, t_d;

  always_comb begin
    t_a = (s1_t > 16'd18622) ? s1_t - 16'd466 : s1_t;
    t_b = (t_a > 16'd4535) ? t_a - kjtc_pkg::GAP_KANJI2 : t_a;
    t_c = (t_b > 16'd3074) ? t_b - 16'd44 : t_b;
    t_d = t_c - 16'd95;
  end

  // Stage 3: row number, t / 160 as (t >> 5) / 5 by reciprocal.
  logic [24:0] q_prod;

  assign q_prod = 25'(s2_t[15:5] * kjtc_pkg::RECIP_5);

  // Stage 4: column, row and byte pair, then the three fixed substitutions.
  logic [15:0]     q_times;
  logic [15:0]     col;
  logic [7:0]      a_b, b_b;
  logic [7:0]      a_s, b_s;
  kjtc_pkg::qent_t s4_in;

  always_comb begin
    q_times = {s3_q, 7'b0} + {2'b00, s3_q, 5'b0};
    col     = s3_t - q_times;
    a_b     = s3_q[7:0] + kjtc_pkg::KSC_BASE;
    b_b     = col[7:0] + kjtc_pkg::KSC_BASE;
    a_s     = a_b;
    b_s     = b_b;
    if (a_b == 8'hA8 && b_b >= kjtc_pkg::KSC_BASE) begin
      unique case (b_b)
        8'hA1: begin
          a_s = 8'hBE;
          b_s = 8'hC6;
        end
        8'hA2: begin
          a_s = 8'hB7;
          b_s = 8'hB8;
        end
        8'hA3: begin
          a_s = 8'hB8;
          b_s = 8'hD5;
        end
        default: begin
          a_s = a_b;
          b_s = b_b;
        end
      endcase
    end
    // Mapped pairs carry the new bytes into stage 4.
    s4_in = s3_ent;
    if (s3_map) begin
      s4_in.hi = a_s;
      s4_in.lo = b_s;
    end
  end

  // Valid bits advance with the shared enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ent <= in_ent;
      s1_map <= map_lin;
      s1_t   <= t_lin;

      s2_ent <= s1_ent;
      s2_map <= s1_map;
      s2_t   <= t_d;

      s3_ent <= s2_ent;
      s3_map <= s2_map;
      s3_t   <= s2_t;
      s3_q   <= q_prod[24:16];

      s4_ent <= s4_in;

      out_ent <= s4_ent;
      out_kor <= kjtc_pkg::korean_pair(s4_ent.hi, s4_ent.lo, cfg);
    end
  end

endmodule

// ----- src/kjtc_tally.sv -----
// Back-end tail: saturating counters, level verdict and the result register.
`timescale 1ns / 1ps

module kjtc_tally #(
  parameter int COUNT_WIDTH = kjtc_pkg::COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  kjtc_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  input  kjtc_pkg::qent_t                in_ent,
  input  logic                           in_kor,
  output logic                           res_valid,
  output logic [kjtc_pkg::M_TDATA_W-1:0] res_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam int PAD_W = kjtc_pkg::M_TDATA_W - 1 - 2 * kjtc_pkg::RES_W;

  logic [COUNT_WIDTH-1:0] k_tally, j_tally;
  logic [COUNT_WIDTH-1:0] k_next, j_next;
  logic                   fin_valid;
  logic [COUNT_WIDTH-1:0] fin_k, fin_j;
  logic [COUNT_WIDTH+1:0] k_ext, j_ext, j_x2, j_x3;
  logic                   verdict;

  // Saturating bump of the matching counter.
  always_comb begin
    k_next = k_tally;
    j_next = j_tally;
    if (in_valid && in_ent.pair) begin
      if (in_kor) begin
        if (k_tally != CNT_MAX) begin
          k_next = k_tally + COUNT_WIDTH'(1);
        end
      end else if (j_tally != CNT_MAX) begin
        j_next = j_tally + COUNT_WIDTH'(1);
      end
    end
  end

  // Counters, and the final counts latched at the end of a string.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_tally   <= '0;
      j_tally   <= '0;
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= in_valid && in_ent.fin;
      if (in_valid && in_ent.fin) begin
        k_tally <= '0;
        j_tally <= '0;
      end else begin
        k_tally <= k_next;
        j_tally <= j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_k <= k_next;
      fin_j <= j_next;
    end
  end

  // Level rule on the final counts.
  always_comb begin
    k_ext = (COUNT_WIDTH + 2)'(fin_k);
    j_ext = (COUNT_WIDTH + 2)'(fin_j);
    j_x2  = {j_ext[COUNT_WIDTH:0], 1'b0};
    j_x3  = j_x2 + j_ext;
    unique case (cfg.level)
      kjtc_pkg::LEVEL_NO_JAPANESE: verdict = (fin_j == '0);
      kjtc_pkg::LEVEL_MAJORITY:    verdict = (k_ext > j_ext);
      kjtc_pkg::LEVEL_THRICE:      verdict = (k_ext > j_x3);
      kjtc_pkg::LEVEL_ANY_KOREAN:  verdict = (fin_k != '0);
      default:                     verdict = (k_ext > j_x2);
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= {{PAD_W{1'b0}}, kjtc_pkg::RES_W'(fin_j), kjtc_pkg::RES_W'(fin_k), verdict};
    end
  end

endmodule

// ----- src/korean_japanese_text_classifier_unit.sv -----
// Top level of the Korean / Japanese text classifier.
`timescale 1ns / 1ps

// The block takes one string byte per beat on the slave side and, for each zero
// byte that ends a string, gives one result beat on the master side. It accepts
// a byte every cycle: the front end pairs high bytes and decides in the same
// cycle whether the partner is used up, and a four-entry queue feeds a seven-stage
// back end (remap index, gap removal, row by reciprocal, byte pair, class check,
// counting, verdict). The back end holds only while the result register waits on
// m_tready; once the queue fills, s_tready drops until it drains. Configuration
// writes take effect at once and belong in idle time between strings.

`include "korean_japanese_text_classifier_unit_macros.svh"

module korean_japanese_text_classifier_unit #(
  parameter int COUNT_WIDTH = kjtc_pkg::COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [kjtc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [kjtc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kjtc_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] text_byte
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kjtc_pkg::M_TDATA_W-1:0]    m_tdata    // [0] is_korean,
                                                       // [16:1] korean_count,
                                                       // [32:17] japanese_count,
                                                       // [39:33] zero
);

  kjtc_pkg::cfg_t  cfg;
  logic            q_push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  kjtc_pkg::qent_t q_in;
  kjtc_pkg::qent_t q_head;
  logic            pend_valid;
  logic            en;
  logic            rm_valid;
  kjtc_pkg::qent_t rm_ent;
  logic            rm_kor;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level    <= kjtc_pkg::LEVEL_RESET;
      cfg.no_roman <= 1'b0;
      cfg.no_round <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kjtc_pkg::REG_LEVEL:    cfg.level    <= cfg_wdata;
        kjtc_pkg::REG_NO_ROMAN: cfg.no_roman <= cfg_wdata[0];
        kjtc_pkg::REG_NO_ROUND: cfg.no_round <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The whole back end advances unless a result waits to be taken.
  assign en    = !m_tvalid || m_tready;
  assign q_pop = en;

  kjtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .q_full     (q_full),
    .in_ready   (s_tready),
    .q_push     (q_push),
    .q_ent      (q_in),
    .pend_valid (pend_valid)
  );

  kjtc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  kjtc_remap u_remap (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (!q_empty),
    .in_ent    (q_head),
    .out_valid (rm_valid),
    .out_ent   (rm_ent),
    .out_kor   (rm_kor)
  );

  kjtc_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (rm_valid),
    .in_ent    (rm_ent),
    .in_kor    (rm_kor),
    .res_valid (m_tvalid),
    .res_data  (m_tdata)
  );

  // A pushed entry always finds room in the queue.
  `KJTC_ASSERT_IMP(a_no_overflow, clk, rst, q_push, !q_full)
  // The end of a string leaves no high byte waiting.
  `KJTC_ASSERT_NXT(a_fin_clears, clk, rst, s_tvalid && s_tready && s_tdata == 8'h00, !pend_valid)
  // The padding bits of a result are always zero.
  `KJTC_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[39:33] == 7'd0)

endmodule
